### src/mcr_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Pixel type, command codes and the fixed constants of the decision update.
// ----------------------------------------------------------------------------
package mcr_pkg;

	localparam int PIX_W = 16;
	localparam int POINTS = 8;
	localparam int IDX_W = $clog2(POINTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

	// Decision value seed and the two increments of one step.
	localparam int DEC_SEED = 3;
	localparam int DEC_DIAG_ADD = 10;
	localparam int DEC_AXIS_ADD = 6;

	typedef logic signed [PIX_W-1:0] pixel_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

endpackage

### src/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// A load word latches a center and radius and yields the eight mirrored points
// of the first position; each advance word runs one step of the midpoint
// circle walk and yields eight more points, the last flagged by last_of_step,
// with circle_done set on every point of the step that ends the circle. An
// advance with no circle in progress yields nothing. The step is computed
// in the walk registers; the result words leave one per cycle from an output
// stage while out_stall is low, eight words for each load or active advance.
// One further input word is held in the first stage while the output stage
// drains; beyond that, in_stall holds the input.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
	parameter int COORD_BITS = 15,
	parameter int RADIUS_BITS = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [RADIUS_BITS-1:0]      radius,
	output logic                        out_valid,
	input  logic                        out_stall,
	output mcr_pkg::pixel_t             pixel_x,
	output mcr_pkg::pixel_t             pixel_y,
	output logic                        last_of_step,
	output logic                        circle_done
);
	import mcr_pkg::*;

	localparam int OFF_W = RADIUS_BITS + 2;
	localparam int DEC_W = RADIUS_BITS + 7;
	localparam int SUM_W = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 1;
	localparam int EXT_W = (SUM_W > PIX_W) ? SUM_W : PIX_W;

	// Walk state; it also serves as the payload of the first stage.
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic signed [OFF_W-1:0]      ox_q, oy_q;
	logic signed [DEC_W-1:0]      dec_q;
	logic                         active_q;

	logic valid_s1, done_s1;

	logic                         valid_s2, done_s2;
	logic [IDX_W-1:0]             idx_s2;
	logic signed [COORD_BITS-1:0] cx_s2, cy_s2;
	logic signed [OFF_W-1:0]      ox_s2, oy_s2;

	logic in_acc, out_acc, is_load, emit, s2_free, s1_move;
	logic dec_pos, done_step;
	logic signed [OFF_W-1:0] x_inc, y_new;
	logic signed [DEC_W-1:0] diff, dec_step, dec_load;

	assign is_load = (command == CMD_LOAD);
	assign emit = is_load || active_q;

	assign s2_free = !valid_s2 || (out_acc && (idx_s2 == LAST_IDX));
	assign s1_move = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// One step of the walk.
	assign dec_pos = !dec_q[DEC_W-1] && (dec_q != '0);
	assign x_inc = ox_q + OFF_W'(1);
	assign y_new = dec_pos ? (oy_q - OFF_W'(1)) : oy_q;
	assign diff = DEC_W'(x_inc) - DEC_W'(y_new);
	assign dec_step = dec_pos ? (dec_q + (diff <<< 2) + DEC_W'(DEC_DIAG_ADD))
		: (dec_q + (DEC_W'(x_inc) <<< 2) + DEC_W'(DEC_AXIS_ADD));
	assign dec_load = DEC_W'(DEC_SEED) - (DEC_W'(radius) << 1);
	assign done_step = (y_new < x_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			dec_q <= '0;
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
			done_s1 <= 1'b0;
		end else begin
			if (in_acc && emit) begin
				if (is_load) begin
					cx_q <= center_x;
					cy_q <= center_y;
					ox_q <= '0;
					oy_q <= OFF_W'(radius);
					dec_q <= dec_load;
					active_q <= 1'b1;
					done_s1 <= 1'b0;
				end else begin
					ox_q <= x_inc;
					oy_q <= y_new;
					dec_q <= dec_step;
					active_q <= !done_step;
					done_s1 <= done_step;
				end
			end
			if (in_acc) begin
				valid_s1 <= emit;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Output stage: a snapshot of one position, sent as eight words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2 <= '0;
		end else if (s1_move) begin
			valid_s2 <= 1'b1;
			idx_s2 <= '0;
		end else if (out_acc) begin
			if (idx_s2 == LAST_IDX) begin
				valid_s2 <= 1'b0;
			end
			idx_s2 <= idx_s2 + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			cx_s2 <= cx_q;
			cy_s2 <= cy_q;
			ox_s2 <= ox_q;
			oy_s2 <= oy_q;
			done_s2 <= done_s1;
		end
	end

	// Bit 2 of the index swaps the offsets, bit 0 negates the x offset and
	// bit 1 negates the y offset, which gives the octant order.
	logic signed [OFF_W-1:0] off_a, off_b;
	logic signed [EXT_W-1:0] px_full, py_full;

	assign off_a = idx_s2[2] ? oy_s2 : ox_s2;
	assign off_b = idx_s2[2] ? ox_s2 : oy_s2;
	assign px_full = idx_s2[0] ? (EXT_W'(cx_s2) - EXT_W'(off_a))
		: (EXT_W'(cx_s2) + EXT_W'(off_a));
	assign py_full = idx_s2[1] ? (EXT_W'(cy_s2) - EXT_W'(off_b))
		: (EXT_W'(cy_s2) + EXT_W'(off_b));

	assign out_valid = valid_s2;
	assign pixel_x = px_full[PIX_W-1:0];
	assign pixel_y = py_full[PIX_W-1:0];
	assign last_of_step = (idx_s2 == LAST_IDX);
	assign circle_done = done_s2;

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with the first stage empty");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_of_step && !valid_s1) |=> !out_valid)
		else $error("output still valid after the last word of a step");

	a_done_clears_active: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && done_s1) |-> !active_q)
		else $error("circle still active after its final step");

	a_idle_advance_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (command == CMD_ADVANCE) && !active_q) |=> !valid_s1)
		else $error("advance with no circle produced words");

endmodule

### tb/midpoint_circle_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer testbench
// Streams load and advance words into the rasterizer with random gaps and
// output stalls. An internal walk of the midpoint circle predicts the eight
// mirrored pixels of every load and active advance, and each pixel word that
// leaves the block is checked in order against that prediction.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_tb;

	import mcr_pkg::*;

	localparam int COORD_BITS = 15;
	localparam int RADIUS_BITS = 13;
	localparam int DEC_W = RADIUS_BITS + 7;
	localparam int OCTANTS = 8;
	localparam int SEED_TERM = 3;
	localparam int DIAG_TERM = 10;
	localparam int AXIS_TERM = 6;
	localparam int STEP_SCALE = 4;
	localparam int RANDOM_ITEMS = 420;
	localparam int MAX_GAP = 5;
	localparam int MAX_REPORTS = 10;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [RADIUS_BITS-1:0] radius_t;
	typedef logic signed [DEC_W-1:0] dec_t;

	typedef struct {
		cmd_t    cmd;
		coord_t  cx;
		coord_t  cy;
		radius_t r;
		bit      drain;
	} circle_cmd_t;

	typedef struct packed {
		pixel_t px;
		pixel_t py;
		logic   last;
		logic   done;
	} pixel_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_LOAD;
	coord_t center_x = '0;
	coord_t center_y = '0;
	radius_t radius = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pixel_t pixel_x;
	pixel_t pixel_y;
	logic last_of_step;
	logic circle_done;

	circle_cmd_t circle_cmds[$];
	pixel_word_t pixels_due[$];
	circle_cmd_t cur;

	// Predicted state of the circle walk.
	coord_t ctr_x;
	coord_t ctr_y;
	int off_x;
	int off_y;
	dec_t walk_dec;
	bit walking;

	int errors = 0;
	int cycles = 0;
	int send_gap = 0;
	int stall_left = 0;
	bit calm_in = 1'b0;
	bit calm_out = 1'b0;
	bit drain_next = 1'b0;

	midpoint_circle_rasterizer #(
		.COORD_BITS(COORD_BITS),
		.RADIUS_BITS(RADIUS_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.last_of_step(last_of_step),
		.circle_done(circle_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic push_octants(input bit done);
		int a;
		int b;
		pixel_word_t w;
		for (int k = 0; k < OCTANTS; k++) begin
			// The first four points mirror (x,y), the last four mirror (y,x).
			a = (k < 4) ? off_x : off_y;
			b = (k < 4) ? off_y : off_x;
			w.px = pixel_t'(int'(ctr_x) + ((k & 1) ? -a : a));
			w.py = pixel_t'(int'(ctr_y) + ((k & 2) ? -b : b));
			w.last = (k == OCTANTS - 1);
			w.done = done;
			pixels_due.insert(pixels_due.size(), w);
		end
	endtask

	task automatic predict_circle_words(input circle_cmd_t c);
		int d;
		if (c.cmd == CMD_LOAD) begin
			ctr_x = c.cx;
			ctr_y = c.cy;
			off_x = 0;
			off_y = int'(c.r);
			walk_dec = dec_t'(SEED_TERM - 2 * off_y);
			walking = 1'b1;
			push_octants(1'b0);
		end else if (walking) begin
			d = int'(walk_dec);
			off_x++;
			if (walk_dec > 0) begin
				off_y--;
				d = d + STEP_SCALE * (off_x - off_y) + DIAG_TERM;
			end else begin
				d = d + STEP_SCALE * off_x + AXIS_TERM;
			end
			walk_dec = dec_t'(d);
			walking = (off_y >= off_x);
			push_octants(!walking);
		end
	endtask

	function automatic int count_steps(input int r);
		int x;
		int y;
		int d;
		int n;
		x = 0;
		y = r;
		d = SEED_TERM - 2 * r;
		n = 0;
		while (y >= x) begin
			x++;
			if (d > 0) begin
				y--;
				d = d + STEP_SCALE * (x - y) + DIAG_TERM;
			end else begin
				d = d + STEP_SCALE * x + AXIS_TERM;
			end
			n++;
		end
		return n;
	endfunction

	task automatic add_cmd(input cmd_t cmd, input coord_t cx, input coord_t cy, input radius_t r);
		circle_cmd_t c;
		c.cmd = cmd;
		c.cx = cx;
		c.cy = cy;
		c.r = r;
		c.drain = drain_next;
		drain_next = 1'b0;
		circle_cmds.insert(circle_cmds.size(), c);
	endtask

	// A load followed by n advances whose unused fields carry random bits.
	task automatic add_circle(input coord_t cx, input coord_t cy, input radius_t r, input int n);
		add_cmd(CMD_LOAD, cx, cy, r);
		for (int i = 0; i < n; i++)
			add_cmd(CMD_ADVANCE, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom));
	endtask

	// Driver: holds a stalled word, otherwise waits out its gap and sends the next.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_LOAD;
			center_x <= '0;
			center_y <= '0;
			radius <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_circle_words(cur);
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (circle_cmds.size() != 0 &&
						!(circle_cmds[0].drain && pixels_due.size() != 0)) begin
					cur = circle_cmds.pop_front();
					command <= cur.cmd;
					center_x <= cur.cx;
					center_y <= cur.cy;
					radius <= cur.r;
					in_valid <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						calm_in = !calm_in;
					send_gap <= calm_in ? 0 : $urandom_range(0, MAX_GAP);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted pixel word and draws the stall before the next.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pixels_due.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected pixel word x=%0d y=%0d last=%0b done=%0b",
							pixel_x, pixel_y, last_of_step, circle_done);
				end else begin
					pixel_word_t w;
					w = pixels_due.pop_front();
					if (pixel_x !== w.px || pixel_y !== w.py ||
							last_of_step !== w.last || circle_done !== w.done) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("pixel mismatch: expected x=%0d y=%0d last=%0b done=%0b,",
								w.px, w.py, w.last, w.done,
								" got x=%0d y=%0d last=%0b done=%0b",
								pixel_x, pixel_y, last_of_step, circle_done);
					end
				end
				if ($urandom_range(0, 39) == 0)
					calm_out = !calm_out;
				if (calm_out) begin
					stall_left <= 0;
					out_stall <= 1'b0;
				end else begin
					int n;
					n = $urandom_range(0, MAX_GAP);
					stall_left <= n;
					out_stall <= (n != 0);
				end
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= (stall_left > 1);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int busy;
		int pick;
		int full;
		int n;
		radius_t r;
		coord_t cmax;
		coord_t cmin;

		cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
		cmin = {1'b1, {(COORD_BITS-1){1'b0}}};

		// Directed part: idle advances, zero radius, extreme centers and radii,
		// and a load that cuts a running circle short.
		add_cmd(CMD_ADVANCE, cmax, cmin, '1);
		add_circle('0, '0, '0, 2);
		add_circle(cmax, cmax, radius_t'(1), 1);
		add_circle(cmin, cmin, '1, 3);
		add_circle(cmax, cmin, '1, 1);
		add_circle(coord_t'(-1), coord_t'(1), radius_t'(5), count_steps(5));
		add_cmd(CMD_ADVANCE, '0, '0, '0);
		add_cmd(CMD_LOAD, cmin, cmax, radius_t'(2));
		add_circle('0, cmax, radius_t'(1 << (RADIUS_BITS - 1)), 1);

		// Random part: mostly complete circles, some cut short or overrun.
		drain_next = 1'b1;
		busy = 0;
		while (busy < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				add_cmd(CMD_ADVANCE, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom));
			end else begin
				if (pick < 75)
					r = radius_t'($urandom_range(0, 24));
				else if (pick < 92)
					r = radius_t'($urandom_range(25, 200));
				else
					r = radius_t'($urandom_range(0, (1 << RADIUS_BITS) - 1));
				full = count_steps(int'(r));
				pick = $urandom_range(0, 9);
				if (pick < 6)
					n = full;
				else if (pick < 8)
					n = full + $urandom_range(1, 2);
				else
					n = $urandom_range(0, full);
				if (n > 40)
					n = $urandom_range(1, 40);
				add_circle(coord_t'($urandom), coord_t'($urandom), r, n);
				busy += 1 + ((n < full) ? n : full);
			end
			if ($urandom_range(0, 39) == 0)
				drain_next = 1'b1;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (circle_cmds.size() != 0 || in_valid)
			@(negedge clk);
		while (pixels_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (errors == 0 && pixels_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
src/mcr_pkg.sv
src/midpoint_circle_rasterizer.sv
tb/midpoint_circle_rasterizer_tb.sv
